@@ rtl/sscm_pkg.sv @@
// Shared types and codes for the start/stop coincidence matcher.
package sscm_pkg;

  typedef enum logic [1:0] {
    KIND_STOP  = 2'd0,
    KIND_START = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_stop;
    logic clear_tbl;
    logic start_query;
    logic issue;
    logic advance;
    logic flush;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic more;
    logic pipe_empty;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/sscm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sscm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sscm_ctrl.sv @@
// Controller state machine: accepts words and sequences the stop table scan.
module sscm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic [1:0]            in_kind,
  output logic                  in_tready,
  input  sscm_pkg::dp_stat_t    stat,
  output sscm_pkg::ctrl_cmd_t   cmd
);

  import sscm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_kind == KIND_START)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          state_nxt = stat.out_free ? ST_IDLE : ST_WAIT;
        end else if (!stat.more && stat.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_kind)
            KIND_STOP:  cmd.store_stop = 1'b1;
            KIND_CLEAR: cmd.clear_tbl  = 1'b1;
            KIND_START: begin
              cmd.start_query = 1'b1;
              cmd.flush       = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          // The compare stage holds its entry until the output register frees up.
          if (stat.out_free) begin
            cmd.load_out = 1'b1;
            cmd.flush    = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
          cmd.issue   = stat.more;
        end
      end
      ST_WAIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.flush    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_wait_holds_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> stat.hit)
    else $error("waiting for output without a held match");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("output register loaded while still occupied");

endmodule

@@ rtl/sscm_dp.sv @@
// Datapath: stop table, scan pipeline, distance compare and output register.
module sscm_dp #(
  parameter int STOP_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sscm_pkg::ctrl_cmd_t  cmd,
  output sscm_pkg::dp_stat_t   stat,
  input  logic [63:0]          in_time,
  input  logic                 cfg_wr,
  input  logic [62:0]          cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,
  output logic                 out_tuser
);

  import sscm_pkg::*;

  localparam int AW = (STOP_DEPTH > 1) ? $clog2(STOP_DEPTH) : 1;
  localparam int CW = $clog2(STOP_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STOP_DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic [62:0]   window_r, window_nxt;
  logic [63:0]   start_r, start_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [63:0]   dist_r, dist_nxt;
  logic [63:0]   stop_r, stop_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_start_r, out_start_nxt;
  logic [63:0]   out_stop_r, out_stop_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          wr_en;
  logic [63:0]   stop_rd;
  logic [64:0]   diff_st;
  logic [64:0]   diff_ts;

  assign wr_en = cmd.store_stop && (count_r < DEPTH_C);

  sscm_ram #(
    .WIDTH (64),
    .DEPTH (STOP_DEPTH)
  ) u_stop_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_time),
    .rd_en   (cmd.issue),
    .rd_addr (scan_idx_r[AW-1:0]),
    .rd_data (stop_rd)
  );

  // Both differences at 65 bits; the one that is not negative is the distance.
  assign diff_st = {stop_rd[63], stop_rd} - {start_r[63], start_r};
  assign diff_ts = {start_r[63], start_r} - {stop_rd[63], stop_rd};

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    scan_idx_nxt  = scan_idx_r;
    window_nxt    = cfg_wr ? cfg_data : window_r;
    start_nxt     = cmd.start_query ? in_time : start_r;
    rd_vld_nxt    = rd_vld_r;
    cmp_vld_nxt   = cmp_vld_r;
    dist_nxt      = dist_r;
    stop_nxt      = stop_r;

    if (cmd.store_stop) begin
      if (wr_en) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.clear_tbl) begin
      count_nxt = '0;
    end

    if (cmd.start_query) begin
      scan_idx_nxt = '0;
    end else if (cmd.issue) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
    end

    if (cmd.advance) begin
      rd_vld_nxt  = cmd.issue;
      cmp_vld_nxt = rd_vld_r;
      dist_nxt    = diff_st[64] ? diff_ts[63:0] : diff_st[63:0];
      stop_nxt    = stop_rd;
    end
    if (cmd.flush) begin
      rd_vld_nxt  = 1'b0;
      cmp_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    out_stop_nxt  = out_stop_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_start_nxt = start_r;
      out_stop_nxt  = stop_r;
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      window_r    <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      window_r    <= window_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    dist_r      <= dist_nxt;
    stop_r      <= stop_nxt;
    out_start_r <= out_start_nxt;
    out_stop_r  <= out_stop_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign stat.hit        = cmp_vld_r && (dist_r <= {1'b0, window_r});
  assign stat.more       = scan_idx_r < count_r;
  assign stat.pipe_empty = !rd_vld_r && !cmp_vld_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_stop_r, out_start_r};
  assign out_tuser  = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stop count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (scan_idx_r < count_r))
    else $error("scan read past the last stored stop");

endmodule

@@ rtl/start_stop_coincidence_matcher.sv @@
// Top level of the start/stop coincidence matcher.
//
// Usage: words arrive on the in_ channel. in_tuser carries the kind (stop,
// start or clear) and in_tdata the signed 64-bit timestamp. A stop word is
// appended to the stop table; when the table already holds STOP_DEPTH stops
// it is dropped and a sticky overflow flag is set. A clear word empties the
// table but keeps the flag. A start word is compared with the stored stops
// in load order, and the first one within match_window yields one word on
// the out_ channel; a start with no partner yields nothing.
// A start word scans one table entry per cycle through the RAM read port;
// each read passes the RAM read register and the compare register, and a
// match is then loaded into the output register. A start with no match
// keeps the block busy until every stored stop has been read and compared.
// The cfg_ channel writes match_window and is always ready.
// Reset clears the stop count, the overflow flag and match_window; the
// table contents are not cleared. When the receiver stalls, one result
// waits in the output register; a further match holds the scan until it
// is taken, while input stalls only during a scan and while a match waits.
module start_stop_coincidence_matcher #(
  parameter int STOP_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] time_value
  input  logic [1:0]   in_tuser,   // [1:0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] matched_start, [127:64] matched_stop
  output logic         out_tuser,  // [0] table_overflowed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [62:0]  cfg_data
);

  import sscm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  sscm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sscm_dp #(
    .STOP_DEPTH (STOP_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_time    (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the start/stop coincidence matcher.
module testbench;
  import sscm_pkg::*;

  localparam int STOP_DEPTH = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  // A start with no partner keeps the block busy until it has scanned every stored stop.
  localparam int SETTLE_CYCLES = STOP_DEPTH + 8;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WINDOW_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {ROW_WORD, ROW_WINDOW} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PAIR} row_chk_t;

  typedef struct packed {
    row_op_t     op;
    logic [1:0]  kind;
    logic [63:0] value;
    row_chk_t    chk;
    logic [63:0] exp_stop;
    logic        exp_ovf;
  } dir_row_t;

  typedef struct packed {
    logic        ovf;
    logic [63:0] stop;
    logic [63:0] start;
  } pair_t;

  localparam int N_ROWS = 28;

  // Window starts at its reset value of zero; later rows move it to the top and to ten.
  dir_row_t dir_rows [0:N_ROWS-1] = '{
    '{ROW_WORD,   KIND_START,  64'd5,      CHK_NONE,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   64'd5,      CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd5,      CHK_PAIR,  64'd5,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd6,      CHK_NONE,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   TIME_MIN,   CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  TIME_MIN,   CHK_PAIR,  TIME_MIN,   1'b0},
    '{ROW_WORD,   KIND_STOP,   TIME_MAX,   CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  TIME_MAX,   CHK_PAIR,  TIME_MAX,   1'b0},
    '{ROW_WORD,   KIND_UNUSED, 64'd6,      CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd6,      CHK_NONE,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd5,      CHK_PAIR,  64'd5,      1'b0},
    '{ROW_WORD,   KIND_CLEAR,  64'd0,      CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd5,      CHK_NONE,  64'd0,      1'b0},
    '{ROW_WINDOW, KIND_STOP,   WINDOW_MAX, CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   TIME_MIN,   CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  TIME_MAX,   CHK_NONE,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   64'd0,      CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  TIME_MAX,   CHK_PAIR,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  TIME_MIN,   CHK_PAIR,  TIME_MIN,   1'b0},
    '{ROW_WINDOW, KIND_STOP,   64'd10,     CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_CLEAR,  64'd0,      CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   64'd100,    CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_STOP,   64'd200,    CHK_MODEL, 64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd205,    CHK_PAIR,  64'd200,    1'b0},
    '{ROW_WORD,   KIND_START,  64'd111,    CHK_NONE,  64'd0,      1'b0},
    '{ROW_WORD,   KIND_START,  64'd90,     CHK_PAIR,  64'd100,    1'b0},
    '{ROW_WORD,   KIND_START,  64'd110,    CHK_PAIR,  64'd100,    1'b0},
    '{ROW_WORD,   KIND_START,  64'd89,     CHK_NONE,  64'd0,      1'b0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // [63:0] time_value
  logic [1:0]   in_tuser = '0;   // [1:0] kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // [63:0] matched_start, [127:64] matched_stop
  logic         out_tuser;       // [0] table_overflowed
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [62:0]  cfg_data = '0;

  // Own copy of the matcher state.
  logic [63:0] stop_model [STOP_DEPTH];
  int unsigned stop_fill = 0;
  logic        ovf_model = 1'b0;
  logic [62:0] window_model = '0;

  pair_t pending_pairs [$];
  int errors = 0;
  int words_sent = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  start_stop_coincidence_matcher #(.STOP_DEPTH(STOP_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Exact distance of two signed times, formed at 65 bits so it cannot wrap.
  function automatic logic [64:0] time_gap(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] d;
    d = $signed({a[63], a}) - $signed({b[63], b});
    return d[64] ? -d : d;
  endfunction

  task automatic pair_word(input logic [1:0] kind, input logic [63:0] tv,
                           output logic hit, output pair_t res);
    hit = 1'b0;
    res = '0;
    case (kind)
      KIND_STOP: begin
        if (stop_fill < STOP_DEPTH) begin
          stop_model[stop_fill] = tv;
          stop_fill++;
        end else begin
          ovf_model = 1'b1;
        end
      end
      KIND_CLEAR: stop_fill = 0;
      KIND_START: begin
        for (int i = 0; i < stop_fill; i++) begin
          if (!hit && time_gap(stop_model[i], tv) <= {2'b00, window_model}) begin
            hit = 1'b1;
            res.start = tv;
            res.stop = stop_model[i];
            res.ovf = ovf_model;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [1:0] kind, input logic [63:0] tv,
                           input row_chk_t chk, input logic [63:0] exp_stop,
                           input logic exp_ovf);
    logic  hit;
    pair_t res;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= tv;
    do @(posedge clk); while (!in_tready);
    pair_word(kind, tv, hit, res);
    if (chk == CHK_MODEL && hit) begin
      pending_pairs.insert(pending_pairs.size(), res);
    end else if (chk == CHK_PAIR) begin
      res.start = tv;
      res.stop = exp_stop;
      res.ovf = exp_ovf;
      pending_pairs.insert(pending_pairs.size(), res);
    end
    if (kind != KIND_UNUSED) words_sent++;
  endtask

  task automatic send_checked(input logic [1:0] kind, input logic [63:0] tv);
    send_word(kind, tv, CHK_MODEL, 64'd0, 1'b0);
  endtask

  // Waits until every pending pair has come out and a silent scan has had time to end.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [62:0] w);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_model = w;
  endtask

  function automatic logic [63:0] seed_time();
    case ($urandom_range(0, 5))
      0: return TIME_MIN;
      1: return TIME_MAX;
      2: return 64'd0;
      default: return rand64();
    endcase
  endfunction

  // Offsets around the window edge, inside it, and anywhere at all.
  function automatic logic [63:0] near_delta();
    logic [63:0] w;
    logic [63:0] x;
    w = {1'b0, window_model};
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return w;
      2: return -w;
      3: return w + 64'd1;
      4: return -(w + 64'd1);
      5: begin
        x = rand64() % (w + 64'd1);
        return $urandom_range(1) ? x : -x;
      end
      default: return rand64();
    endcase
  endfunction

  task automatic run_sequence();
    logic [63:0] loaded [$];
    logic [63:0] base;
    logic [63:0] pick;
    logic [1:0]  k;
    int          n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        k = 2'($urandom_range(0, 3));
        send_checked(k, rand64());
      end
      return;
    end
    if ($urandom_range(1)) send_checked(KIND_CLEAR, rand64());
    base = seed_time();
    n = $urandom_range(1, 10);
    repeat (n) begin
      pick = ($urandom_range(9) == 0) ? rand64() :
             base + 64'($urandom_range(0, 3000)) - 64'd1500;
      loaded.insert(loaded.size(), pick);
      send_checked(KIND_STOP, pick);
    end
    n = $urandom_range(1, 6);
    repeat (n) begin
      pick = loaded[$urandom_range(0, loaded.size() - 1)];
      send_checked(KIND_START, pick + near_delta());
    end
  endtask

  task automatic run_phase(input int snd, input int rcv, input logic [62:0] w,
                           input int target, input bit hold);
    int first;
    set_window(w);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    if (hold) hold_req++;
    first = words_sent;
    while (words_sent - first < target) run_sequence();
  endtask

  // Loads the table past its depth, then queries the deepest entry and a dropped stop.
  task automatic fill_stop_table();
    logic [63:0] base;
    base = rand64();
    send_checked(KIND_CLEAR, 64'd0);
    for (int i = 0; i < STOP_DEPTH + 3; i++) send_checked(KIND_STOP, base + 64'(4 * i));
    send_checked(KIND_START, base + 64'(4 * (STOP_DEPTH - 1)));
    send_checked(KIND_START, base + 64'(4 * (STOP_DEPTH + 1)));
    send_checked(KIND_START, base + 64'd2);
    send_checked(KIND_STOP, base);
    send_checked(KIND_START, base + 64'd8);
    send_checked(KIND_CLEAR, 64'd0);
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual start %h stop %h ovf %b",
                 $time, out_tdata[63:0], out_tdata[127:64], out_tuser);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("matched_start", want.start, out_tdata[63:0]);
        check_field("matched_stop", want.stop, out_tdata[127:64]);
        check_field("table_overflowed", {63'd0, want.ovf}, {63'd0, out_tuser});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_WINDOW)
        set_window(dir_rows[i].value[62:0]);
      else
        send_word(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].chk,
                  dir_rows[i].exp_stop, dir_rows[i].exp_ovf);
    end

    run_phase(0, 0, 63'd0, 70, 1'b0);
    run_phase(0, 0, WINDOW_MAX[62:0], 70, 1'b0);
    run_phase(54, 0, 63'($urandom_range(1, 1000)), 70, 1'b0);
    run_phase(54, 0, 63'(rand64()), 70, 1'b0);
    // The receiver holds off at the start of this phase while words keep coming.
    run_phase(0, 54, 63'($urandom_range(16, 5000)), 140, 1'b1);
    run_phase(25, 25, 63'(rand64() >> $urandom_range(0, 62)), 100, 1'b0);
    set_window(63'd0);
    fill_stop_table();
    // The overflow flag stays set across the clear, so every pair below carries it.
    run_phase(25, 25, WINDOW_MAX[62:0], 40, 1'b0);

    drain_results();
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
